FILE: design/radix_digit_formatter_top_defines.svh
// ----------------------------------------------------------------------------
// Radix digit formatter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_FORMATTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_FORMATTER_TOP_DEFINES_SVH

// Same-cycle implication
`define RDF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RDF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rdf_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit formatter package
// Sizes, symbol codes and the command/status bundles shared by the block.
// ----------------------------------------------------------------------------
package rdf_pkg;

	// Alphabet store
	localparam int MAX_SYMBOLS = 64;
	localparam int WORD_COUNT  = 8;
	localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
	localparam int SYM_W       = 8;
	localparam int BYTE_IDX_W  = 6;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 64;

	// Radix and digit widths follow from the alphabet cap
	localparam int LEN_W   = $clog2(MAX_SYMBOLS + 1);
	localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;

	// Number and digit stack
	localparam int NUM_W      = 32;
	localparam int MAX_DIGITS = 32;
	localparam int ND_W       = $clog2(MAX_DIGITS + 1);
	localparam int STK_W      = $clog2(MAX_DIGITS);
	localparam int RCNT_W     = $clog2(NUM_W + 1);

	// Symbol codes
	localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
	localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;
	localparam logic [SYM_W-1:0] NUL_SYM   = 8'h00;
	localparam int               MIN_RADIX = 2;

	// Controller to datapath
	typedef struct packed {
		logic scan_start;
		logic scan_step;
		logic recip_start;
		logic recip_step;
		logic load;
		logic mul;
		logic mqr;
		logic rem;
		logic emit_bad;
		logic emit_sign;
		logic emit_dig;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic dirty;
		logic scan_end;
		logic alpha_bad;
		logic recip_last;
		logic neg;
		logic quot_zero;
		logic dig_last;
		logic out_free;
	} sts_t;

endpackage

FILE: design/rdf_if.sv
// ----------------------------------------------------------------------------
// Radix digit formatter channels
// Valid/ready channels for the number input and the symbol output.
// ----------------------------------------------------------------------------
interface rdf_num_if
	import rdf_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

interface rdf_sym_if
	import rdf_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic             bad_alphabet;

	modport source (output valid, output symbol, output last, output bad_alphabet,
		input ready);
	modport sink (input valid, input symbol, input last, input bad_alphabet,
		output ready);
endinterface

FILE: design/rdf_ctrl.sv
// ----------------------------------------------------------------------------
// Radix digit formatter controller
// Sequences alphabet check, reciprocal set-up, digit division and emission.
// ----------------------------------------------------------------------------
module rdf_ctrl
	import rdf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_SCAN      = 9'b000000010,
		S_RECIP     = 9'b000000100,
		S_MUL       = 9'b000001000,
		S_MQR       = 9'b000010000,
		S_REM       = 9'b000100000,
		S_EMIT_BAD  = 9'b001000000,
		S_EMIT_SIGN = 9'b010000000,
		S_EMIT_DIG  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// Input taken only once the alphabet is checked
	assign in_ready = (state_q == S_IDLE) && !sts.dirty;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (sts.dirty) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.alpha_bad ? S_EMIT_BAD : S_MUL;
				end
			end
			S_SCAN: begin
				if (!sts.scan_end) begin
					cmd.scan_step = 1'b1;
				end else if (sts.alpha_bad) begin
					state_d = S_IDLE;
				end else begin
					cmd.recip_start = 1'b1;
					state_d         = S_RECIP;
				end
			end
			S_RECIP: begin
				cmd.recip_step = 1'b1;
				if (sts.recip_last) begin
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_MQR;
			end
			S_MQR: begin
				cmd.mqr = 1'b1;
				state_d = S_REM;
			end
			S_REM: begin
				cmd.rem = 1'b1;
				if (!sts.quot_zero) begin
					state_d = S_MUL;
				end else begin
					state_d = sts.neg ? S_EMIT_SIGN : S_EMIT_DIG;
				end
			end
			S_EMIT_BAD: begin
				if (sts.out_free) begin
					cmd.emit_bad = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_EMIT_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = S_EMIT_DIG;
				end
			end
			S_EMIT_DIG: begin
				if (sts.out_free) begin
					cmd.emit_dig = 1'b1;
					if (sts.dig_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/rdf_datapath.sv
// ----------------------------------------------------------------------------
// Radix digit formatter datapath
// Alphabet registers and checker, reciprocal divider, digit divider with
// digit stack, and the output register.
// ----------------------------------------------------------------------------
module rdf_datapath
	import rdf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [NUM_W-1:0] number,
	input  logic                   out_ready,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	output logic [SYM_W-1:0]       symbol,
	output logic                   last,
	output logic                   bad_alphabet
);

	logic [CFG_DATA_W-1:0]  alpha_q [WORD_COUNT];
	logic                   dirty_q;
	logic [LEN_W-1:0]       scan_idx_q;
	logic [LEN_W-1:0]       len_q;
	logic                   bad_q;
	logic [(1<<SYM_W)-1:0]  seen_q;
	logic [RCNT_W-1:0]      rcnt_q;
	logic [LEN_W-1:0]       rrem_q;
	logic [NUM_W-1:0]       recip_q;
	logic [NUM_W-1:0]       mag_q;
	logic                   neg_q;
	logic [NUM_W-1:0]       qest_q;
	logic [NUM_W-1:0]       qr_q;
	logic [ND_W-1:0]        nd_q;
	logic [DIGIT_W-1:0]     stack_q [MAX_DIGITS];
	logic                   ov_q;
	logic [SYM_W-1:0]       osym_q;
	logic                   olast_q;
	logic                   obad_q;

	logic [BYTE_IDX_W-1:0]  rd_addr;
	logic [CFG_DATA_W-1:0]  rd_word;
	logic [SYM_W-1:0]       rd_byte;
	logic [ND_W-1:0]        nd_dec;
	logic [DIGIT_W-1:0]     top_digit;
	logic [LEN_W:0]         rt;
	logic                   rge;
	logic [LEN_W:0]         rt_sub;
	logic [NUM_W-1:0]       raw;
	logic [2*NUM_W-1:0]     prod;
	logic [NUM_W+LEN_W-1:0] qr_full;
	logic [NUM_W-1:0]       diff;
	logic [LEN_W:0]         remv;
	logic                   rem_ge;
	logic [LEN_W:0]         dig;
	logic [NUM_W-1:0]       q_next;
	logic                   out_free;

	// Single alphabet read port: digit on top of the stack while any are
	// stacked, otherwise the scan index (the stack is empty whenever idle)
	assign nd_dec    = nd_q - 1'b1;
	assign top_digit = stack_q[nd_dec[STK_W-1:0]];
	assign rd_addr   = (nd_q != '0) ? BYTE_IDX_W'(top_digit) : BYTE_IDX_W'(scan_idx_q);
	assign rd_word   = alpha_q[rd_addr[BYTE_IDX_W-1:3]];
	assign rd_byte   = rd_word[{rd_addr[2:0], 3'b000} +: SYM_W];

	// Configuration registers; any write forces a fresh check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				alpha_q[i] <= '0;
			end
			dirty_q <= 1'b1;
		end else begin
			if (cfg_we && (cfg_index < CFG_INDEX_W'(WORD_COUNT))) begin
				alpha_q[cfg_index[WORD_IDX_W-1:0]] <= cfg_data;
			end
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (cmd.scan_start) begin
				dirty_q <= 1'b0;
			end
		end
	end

	// Alphabet check, one symbol a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			len_q      <= '0;
			bad_q      <= 1'b0;
			seen_q     <= '0;
		end else if (cmd.scan_start) begin
			scan_idx_q <= '0;
			len_q      <= '0;
			bad_q      <= 1'b0;
			seen_q     <= '0;
		end else if (cmd.scan_step) begin
			if ((rd_byte == PLUS_SYM) || (rd_byte == MINUS_SYM) || seen_q[rd_byte]) begin
				bad_q <= 1'b1;
			end else begin
				seen_q[rd_byte] <= 1'b1;
				len_q           <= len_q + 1'b1;
				scan_idx_q      <= scan_idx_q + 1'b1;
			end
		end
	end

	// Reciprocal floor(2^NUM_W / radix), restoring division one bit a cycle
	assign rt     = {rrem_q, (rcnt_q == RCNT_W'(NUM_W))};
	assign rge    = rt >= {1'b0, len_q};
	assign rt_sub = rt - {1'b0, len_q};

	always_ff @(posedge clk) begin
		if (cmd.recip_start) begin
			rcnt_q <= RCNT_W'(NUM_W);
			rrem_q <= '0;
		end else if (cmd.recip_step) begin
			rcnt_q  <= rcnt_q - 1'b1;
			rrem_q  <= rge ? rt_sub[LEN_W-1:0] : rt[LEN_W-1:0];
			recip_q <= {recip_q[NUM_W-2:0], rge};
		end
	end

	// Digit division: estimate by reciprocal, back-multiply, correct once
	assign raw     = NUM_W'(number);
	assign prod    = {{NUM_W{1'b0}}, mag_q} * {{NUM_W{1'b0}}, recip_q};
	assign qr_full = qest_q * len_q;
	assign diff    = mag_q - qr_q;
	assign remv    = diff[LEN_W:0];
	assign rem_ge  = remv >= {1'b0, len_q};
	assign dig     = rem_ge ? (remv - {1'b0, len_q}) : remv;
	assign q_next  = qest_q + NUM_W'(rem_ge);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= number[NUM_W-1];
			mag_q <= number[NUM_W-1] ? (~raw + 1'b1) : raw;
		end else if (cmd.rem) begin
			mag_q <= q_next;
		end
		if (cmd.mul) begin
			qest_q <= prod[2*NUM_W-1:NUM_W];
		end
		if (cmd.mqr) begin
			qr_q <= qr_full[NUM_W-1:0];
		end
		if (cmd.rem) begin
			stack_q[nd_q[STK_W-1:0]] <= dig[DIGIT_W-1:0];
		end
	end

	// Digit count: grows while dividing, shrinks while emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= '0;
		end else if (cmd.load) begin
			nd_q <= '0;
		end else if (cmd.rem) begin
			nd_q <= nd_q + 1'b1;
		end else if (cmd.emit_dig) begin
			nd_q <= nd_dec;
		end
	end

	// Output register
	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit_bad || cmd.emit_sign || cmd.emit_dig) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bad) begin
			osym_q  <= NUL_SYM;
			olast_q <= 1'b1;
			obad_q  <= 1'b1;
		end else if (cmd.emit_sign) begin
			osym_q  <= MINUS_SYM;
			olast_q <= 1'b0;
			obad_q  <= 1'b0;
		end else if (cmd.emit_dig) begin
			osym_q  <= rd_byte;
			olast_q <= (nd_q == ND_W'(1));
			obad_q  <= 1'b0;
		end
	end

	assign out_valid    = ov_q;
	assign symbol       = osym_q;
	assign last         = olast_q;
	assign bad_alphabet = obad_q;

	// Status to the controller
	assign sts.dirty      = dirty_q;
	assign sts.scan_end   = (scan_idx_q == LEN_W'(MAX_SYMBOLS)) || (rd_byte == NUL_SYM)
		|| bad_q;
	assign sts.alpha_bad  = bad_q || (len_q < LEN_W'(MIN_RADIX));
	assign sts.recip_last = (rcnt_q == '0);
	assign sts.neg        = neg_q;
	assign sts.quot_zero  = (q_next == '0);
	assign sts.dig_last   = (nd_q == ND_W'(1));
	assign sts.out_free   = out_free;

endmodule

FILE: design/radix_digit_formatter_top.sv
// ----------------------------------------------------------------------------
// Radix digit formatter
// Writes a signed 32-bit number as text in the radix of a configured alphabet.
// ----------------------------------------------------------------------------
// Usage:
//  - number_ch carries one signed 32-bit number per beat; symbol_ch returns
//    its text one symbol per beat, most significant digit first, a leading
//    '-' for negatives, last set on the final symbol.
//  - An invalid alphabet gives a single beat with symbol 0, last and
//    bad_alphabet set.
//  - The alphabet is written through cfg_we/cfg_index/cfg_data; indices above
//    7 are ignored. After reset and after any write the alphabet is checked,
//    one symbol a cycle, then, if it is valid, a bit-serial divide forms the
//    radix reciprocal; number_ch.ready stays low meanwhile.
//  - Per number: after it is accepted, each digit passes through a reciprocal
//    multiply, a back-multiply and a correction, then the symbols go out one
//    per cycle while the receiver is ready.
//  - The digit loop sets the rate; one number is in work at a time, the next
//    accepted once its last symbol sits in the output register.
//  - A stalled receiver holds the output register and pauses emission.
//  - Reset clears the alphabet, so the block reports a bad alphabet until
//    it is written.
module radix_digit_formatter_top
	import rdf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	rdf_num_if.sink                number_ch,
	rdf_sym_if.source              symbol_ch
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	rdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number_ch.valid),
		.in_ready (number_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and storage
	rdf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.number       (number_ch.number),
		.out_ready    (symbol_ch.ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (symbol_ch.valid),
		.symbol       (symbol_ch.symbol),
		.last         (symbol_ch.last),
		.bad_alphabet (symbol_ch.bad_alphabet)
	);

endmodule

FILE: design/rdf_checker.sv
// ----------------------------------------------------------------------------
// Radix digit formatter port checker
// Watches the top-level channels for lost, invented or malformed beats.
// ----------------------------------------------------------------------------
`include "radix_digit_formatter_top_defines.svh"

module rdf_checker
	import rdf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SYM_W-1:0] symbol,
	input logic             last,
	input logic             bad_alphabet
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       end_beat;

	assign in_beat  = in_valid && in_ready;
	assign end_beat = out_valid && out_ready && last;

	// Numbers taken whose last symbol has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, end_beat};
		end
	end

	`RDF_ASSERT_IMP(a_no_orphan, out_valid, pend_q != 2'd0, "output beat with no number taken")
	`RDF_ASSERT_IMP(a_one_ahead, in_beat, pend_q < 2'd2, "number taken too far ahead of output")
	`RDF_ASSERT_IMP(a_bad_form, out_valid && bad_alphabet, last && (symbol == NUL_SYM), "bad beat malformed")
	`RDF_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(symbol) && $stable(last), "stalled beat changed")

endmodule

bind radix_digit_formatter_top rdf_checker u_rdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (number_ch.valid),
	.in_ready     (number_ch.ready),
	.out_valid    (symbol_ch.valid),
	.out_ready    (symbol_ch.ready),
	.symbol       (symbol_ch.symbol),
	.last         (symbol_ch.last),
	.bad_alphabet (symbol_ch.bad_alphabet)
);
